/* rtl/cnls_pkg.sv */
`timescale 1ns / 1ps
// Package for the character LCD nibble sequencer.
// Holds character and command codes and the nibble reversal function.
// No dependencies.
package cnls_pkg;

    // Escape characters that the sequencer turns into commands, and NUL, which a push ignores.
    localparam logic [7:0] C_CHAR_NUL       = 8'h00;
    localparam logic [7:0] C_CHAR_NEWLINE   = 8'h0A;
    localparam logic [7:0] C_CHAR_CR        = 8'h0D;
    localparam logic [7:0] C_CHAR_TAB       = 8'h09;
    localparam logic [7:0] C_CHAR_BACKSPACE = 8'h08;
    localparam logic [7:0] C_CHAR_BELL      = 8'h07;
    localparam logic [7:0] C_CHAR_FORMFEED  = 8'h0C;
    localparam logic [7:0] C_CHAR_VTAB      = 8'h0B;
    localparam logic [7:0] C_CHAR_QUOTE     = 8'h27;
    localparam logic [7:0] C_CHAR_BACKSLASH = 8'h5C;

    // Display commands sent with RS low.
    localparam logic [7:0] C_ADDR_LINE2     = 8'hC0;
    localparam logic [7:0] C_ADDR_LINE1     = 8'h80;
    localparam logic [7:0] C_CMD_CLEAR      = 8'h01;
    localparam logic [7:0] C_CMD_HOME       = 8'h02;
    localparam logic [7:0] C_CMD_DISP_ON    = 8'h0C;
    localparam logic [7:0] C_CMD_DISP_OFF   = 8'h08;
    localparam logic [7:0] C_CMD_CURSOR_ON  = 8'h0E;
    localparam logic [7:0] C_CMD_BLINK_ON   = 8'h0F;

    localparam logic C_MODE_PUSH = 1'b0;
    localparam logic C_MODE_TICK = 1'b1;

    function automatic logic [3:0] f_rev4(input logic [3:0] v);
        f_rev4 = {v[0], v[1], v[2], v[3]};
    endfunction

endpackage

/* rtl/cnls_in_if.sv */
`timescale 1ns / 1ps
// Input channel of the character LCD nibble sequencer: a push or a tick.
// Stands alone; no package needed.
interface cnls_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] char_in;

    modport source (output valid, output mode, output char_in, input ready);
    modport sink   (input valid, input mode, input char_in, output ready);
endinterface

/* rtl/cnls_out_if.sv */
`timescale 1ns / 1ps
// Output channel of the character LCD nibble sequencer: pin levels and status.
// Stands alone; no package needed.
interface cnls_out_if;
    logic       valid;
    logic       ready;
    logic       rs_line;
    logic       enable_line;
    logic [3:0] data_nibble;
    logic       char_dropped;
    logic       buffer_empty;

    modport source (output valid, output rs_line, output enable_line, output data_nibble,
                    output char_dropped, output buffer_empty, input ready);
    modport sink   (input valid, input rs_line, input enable_line, input data_nibble,
                    input char_dropped, input buffer_empty, output ready);
endinterface

/* rtl/char_lcd_nibble_sequencer_top.sv */
`timescale 1ns / 1ps
// Character LCD nibble sequencer: a result item is registered and valid in the cycle after its input item.
// One item is accepted every cycle; the output register only stalls input when it is full
// and not being taken. The head character is read from the character memory each cycle
// at the next read index, with the write forwarded when it hits that index.
// Synchronous active-low reset clears indices, count, phase, pins and the register;
// the character memory itself is not cleared and needs no clearing pass.
module char_lcd_nibble_sequencer_top
    import cnls_pkg::*;
#(
    parameter int BUFFER_DEPTH = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_wr_data,
    cnls_in_if.sink     i_in,
    cnls_out_if.source  o_out
);

    localparam int IDX_W = $clog2(BUFFER_DEPTH);
    localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);

    typedef enum logic [4:0] {
        PH_IDLE     = 5'd0,
        PH_CHR_HI   = 5'd1,
        PH_CHR_HI_E = 5'd2,
        PH_CHR_LO   = 5'd3,
        PH_CHR_LO_E = 5'd4,
        PH_CHR_END  = 5'd5,
        PH_ADDR_HI  = 5'd10,
        PH_ADDR_HE  = 5'd11,
        PH_ADDR_LO  = 5'd12,
        PH_ADDR_LE  = 5'd13,
        PH_CMD_HI   = 5'd20,
        PH_CMD_HE   = 5'd21,
        PH_CMD_LO   = 5'd22,
        PH_CMD_LE   = 5'd23
    } t_phase;

    logic [7:0]       r_mem [BUFFER_DEPTH];
    logic [7:0]       r_head;

    t_phase           r_phase, n_phase;
    logic [IDX_W-1:0] r_rd_idx, n_rd_idx;
    logic [IDX_W-1:0] r_wr_idx, n_wr_idx;
    logic [CNT_W-1:0] r_fill, n_fill;
    logic [7:0]       r_pending, n_pending;
    logic             r_rs, n_rs;
    logic             r_e, n_e;
    logic [3:0]       r_nib, n_nib;
    logic             r_reverse_nibble;

    logic             r_out_valid;
    logic             r_dropped, n_dropped;
    logic             r_empty;

    logic             accept;
    logic             mem_we;
    logic             has_char;
    logic             escape;
    logic             is_addr;
    logic [7:0]       esc_byte;

    function automatic logic [IDX_W-1:0] f_next(input logic [IDX_W-1:0] i);
        f_next = (i == IDX_W'(BUFFER_DEPTH - 1)) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [3:0] f_drive(input logic [3:0] v, input logic rev);
        f_drive = rev ? f_rev4(v) : v;
    endfunction

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;
    assign has_char   = (r_fill != '0);

    // Escape decode of the character at the head of the buffer.
    always_comb begin
        escape   = 1'b1;
        is_addr  = 1'b0;
        esc_byte = C_CMD_CLEAR;
        unique case (r_head)
            C_CHAR_NEWLINE: begin
                is_addr  = 1'b1;
                esc_byte = C_ADDR_LINE2;
            end
            C_CHAR_CR: begin
                is_addr  = 1'b1;
                esc_byte = C_ADDR_LINE1;
            end
            C_CHAR_TAB:       esc_byte = C_CMD_CLEAR;
            C_CHAR_BACKSPACE: esc_byte = C_CMD_HOME;
            C_CHAR_BELL:      esc_byte = C_CMD_DISP_ON;
            C_CHAR_FORMFEED:  esc_byte = C_CMD_DISP_OFF;
            C_CHAR_VTAB:      esc_byte = C_CMD_CURSOR_ON;
            C_CHAR_QUOTE:     esc_byte = C_CMD_DISP_ON;
            C_CHAR_BACKSLASH: esc_byte = C_CMD_BLINK_ON;
            default:          escape   = 1'b0;
        endcase
    end

    always_comb begin
        n_phase   = r_phase;
        n_rd_idx  = r_rd_idx;
        n_wr_idx  = r_wr_idx;
        n_fill    = r_fill;
        n_pending = r_pending;
        n_rs      = r_rs;
        n_e       = r_e;
        n_nib     = r_nib;
        n_dropped = 1'b0;
        mem_we    = 1'b0;

        if (accept) begin
            if (i_in.mode == C_MODE_PUSH) begin
                if (i_in.char_in != C_CHAR_NUL) begin
                    if (r_fill == CNT_W'(BUFFER_DEPTH)) begin
                        n_dropped = 1'b1;
                    end else begin
                        mem_we   = 1'b1;
                        n_wr_idx = f_next(r_wr_idx);
                        n_fill   = r_fill + 1'b1;
                    end
                end
            end else begin
                unique case (r_phase)
                    PH_IDLE: begin
                        if (has_char) begin
                            if (escape) begin
                                // Escapes leave the buffer at once; the command is held aside.
                                n_pending = esc_byte;
                                n_phase   = is_addr ? PH_ADDR_HI : PH_CMD_HI;
                                n_rd_idx  = f_next(r_rd_idx);
                                n_fill    = r_fill - 1'b1;
                            end else begin
                                n_phase = PH_CHR_HI;
                            end
                        end
                    end
                    PH_CHR_HI: begin
                        n_rs    = 1'b1;
                        n_nib   = f_drive(r_head[7:4], r_reverse_nibble);
                        n_e     = 1'b1;
                        n_phase = PH_CHR_HI_E;
                    end
                    PH_CHR_LO: begin
                        n_nib   = f_drive(r_head[3:0], r_reverse_nibble);
                        n_e     = 1'b1;
                        n_phase = PH_CHR_LO_E;
                    end
                    PH_CHR_END: begin
                        n_rs    = 1'b0;
                        if (has_char) begin
                            n_rd_idx = f_next(r_rd_idx);
                            n_fill   = r_fill - 1'b1;
                        end
                        n_phase = PH_IDLE;
                    end
                    PH_ADDR_HI: begin
                        n_nib   = f_drive(r_pending[7:4], r_reverse_nibble);
                        n_e     = 1'b1;
                        n_phase = PH_ADDR_HE;
                    end
                    PH_ADDR_LO: begin
                        n_nib   = f_drive(r_pending[3:0], r_reverse_nibble);
                        n_e     = 1'b1;
                        n_phase = PH_ADDR_LE;
                    end
                    PH_CMD_HI: begin
                        n_nib   = 4'h0;
                        n_e     = 1'b1;
                        n_phase = PH_CMD_HE;
                    end
                    PH_CMD_LO: begin
                        n_nib   = f_drive(r_pending[3:0], r_reverse_nibble);
                        n_e     = 1'b1;
                        n_phase = PH_CMD_LE;
                    end
                    PH_CHR_HI_E: begin
                        n_e     = 1'b0;
                        n_phase = PH_CHR_LO;
                    end
                    PH_CHR_LO_E: begin
                        n_e     = 1'b0;
                        n_phase = PH_CHR_END;
                    end
                    PH_ADDR_HE: begin
                        n_e     = 1'b0;
                        n_phase = PH_ADDR_LO;
                    end
                    PH_CMD_HE: begin
                        n_e     = 1'b0;
                        n_phase = PH_CMD_LO;
                    end
                    PH_ADDR_LE, PH_CMD_LE: begin
                        n_e     = 1'b0;
                        n_phase = PH_IDLE;
                    end
                    default: begin
                        // A phase without meaning flushes the buffer and returns to idle.
                        n_rd_idx = r_wr_idx;
                        n_fill   = '0;
                        n_phase  = PH_IDLE;
                    end
                endcase
            end
        end
    end

    // Character memory; the head register follows the next read index, and a
    // write to that same entry is forwarded so the head is never stale.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_wr_idx] <= i_in.char_in;
        end
        if (mem_we && (r_wr_idx == n_rd_idx)) begin
            r_head <= i_in.char_in;
        end else begin
            r_head <= r_mem[n_rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase          <= PH_IDLE;
            r_rd_idx         <= '0;
            r_wr_idx         <= '0;
            r_fill           <= '0;
            r_pending        <= '0;
            r_rs             <= 1'b0;
            r_e              <= 1'b0;
            r_nib            <= 4'h0;
            r_reverse_nibble <= 1'b0;
            r_out_valid      <= 1'b0;
            r_dropped        <= 1'b0;
            r_empty          <= 1'b1;
        end else begin
            r_phase   <= n_phase;
            r_rd_idx  <= n_rd_idx;
            r_wr_idx  <= n_wr_idx;
            r_fill    <= n_fill;
            r_pending <= n_pending;
            r_rs      <= n_rs;
            r_e       <= n_e;
            r_nib     <= n_nib;
            if (i_cfg_wr_en) begin
                r_reverse_nibble <= i_cfg_wr_data;
            end
            if (accept) begin
                r_out_valid <= 1'b1;
                r_dropped   <= n_dropped;
                r_empty     <= (n_fill == '0);
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Pin registers change only on accepted items, so they stand as the result payload.
    assign o_out.valid        = r_out_valid;
    assign o_out.rs_line      = r_rs;
    assign o_out.enable_line  = r_e;
    assign o_out.data_nibble  = r_nib;
    assign o_out.char_dropped = r_dropped;
    assign o_out.buffer_empty = r_empty;

endmodule
